// File: src/utcc_pkg.sv
// Types, constants and lookup tables for the Unix time / calendar converter.
// No dependencies; imported by unix_time_calendar_converter_top.
package utcc_pkg;

  // Register stages from the input transfer to the result strobe.
  localparam int unsigned NumStages = 12;

  // Reciprocals for division by constants: q = (x * R) >> S.
  // Each one is exact over the input range that feeds it.
  localparam logic [12:0] Rcp100   = 13'd5243;      // x < 2^12, shift 19
  localparam int unsigned Sh100    = 19;
  localparam logic [25:0] Rcp675   = 26'd50903317;  // x < 2^25, shift 35
  localparam int unsigned Sh675    = 35;
  localparam logic [17:0] Rcp7     = 18'd149797;    // x < 2^17, shift 20
  localparam int unsigned Sh7      = 20;
  localparam logic [20:0] Rcp146097 = 21'd1881476;  // x < 2^20, shift 38
  localparam int unsigned Sh146097 = 38;
  localparam logic [17:0] Rcp3600  = 18'd149131;    // x < 2^17, shift 29
  localparam int unsigned Sh3600   = 29;
  localparam logic [18:0] Rcp1460  = 19'd367720;    // x < 2^18, shift 29
  localparam int unsigned Sh1460   = 29;
  localparam logic [12:0] Rcp60    = 13'd4370;      // x < 2^12, shift 18
  localparam int unsigned Sh60     = 18;
  localparam logic [18:0] Rcp365   = 19'd367720;    // x < 2^18, shift 27
  localparam int unsigned Sh365    = 27;
  localparam logic [11:0] Rcp153   = 12'd3427;      // x < 2^11, shift 19
  localparam int unsigned Sh153    = 19;

  // Days 0000-03-01 .. 1970-01-01 in the March-based count, and leap years in 1..1969.
  localparam logic [19:0] EpochShift  = 20'd719468;
  localparam logic [31:0] LeapsTo1969 = 32'd477;
  localparam logic [11:0] EpochYear   = 12'd1970;

  // Echoed calendar fields for calendar-to-unix requests.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } echo_t;

  // Days before month m in a common year; months 13 and 14 count as 31 days each.
  function automatic logic [8:0] days_before_mon(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd396;
      default: r = 9'd427;
    endcase
    return r;
  endfunction

  // Days before month index mp of a year starting on 1 March.
  function automatic logic [8:0] days_before_mar(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/unix_time_calendar_converter_top.sv
// Unix seconds <-> Gregorian calendar converter, twelve-stage pipeline.
// Depends on utcc_pkg (reciprocal constants, month tables, echo_t).
//
// Usage:
//   Input channel: a request transfers on a rising edge with start_i high and
//   busy_o low. busy_o is always low: the pipeline takes a new request on
//   every clock. req_type_i = 0 converts year/month/day/hour/minute/second
//   to Unix seconds; req_type_i = 1 breaks unix_in_i into calendar fields.
//   Output channel: done_o is high for exactly one cycle per request, with
//   all result ports valid in that cycle. The receiver has no way to stall
//   the block and must take every result when it is shown.
//   The pipeline depth is set by the chain of constant-reciprocal multiplies
//   (days from seconds, era, hour, year of era, month), spread over the
//   stages. Throughput: one item per clock.
//   Results come out in request order.
//   Reset (rst_ni low, asynchronous) clears the valid bits of all stages;
//   items in flight are dropped and no done_o is raised until new requests
//   reach the end of the pipe. Data registers are not reset.
//   In calendar-to-unix mode the calendar outputs echo the inputs; sums wrap
//   modulo 2^32. The weekday is (days since epoch + 4) mod 7, Sunday = 0.
module unix_time_calendar_converter_top
  import utcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [11:0] year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  input  logic [31:0] unix_in_i,
  output logic        done_o,
  output logic [31:0] unix_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [2:0]  weekday_o
);

  // ---------------------------------------------------------------------------
  // Valid bits and side-band that travel along the whole pipe
  // ---------------------------------------------------------------------------
  logic  vld_q  [1:NumStages];
  logic  req_q  [1:NumStages-1];
  echo_t echo_q [1:NumStages-1];

  // Stage-carried datapath values (index = stage that produced it)
  logic [31:0] u_q    [3:11];
  logic [2:0]  era_q  [5:11];
  logic [2:0]  wd_q   [6:11];
  logic [4:0]  hr_q   [6:11];
  logic [17:0] doe_q  [6:9];
  logic [11:0] rem_q  [7:8];
  logic [5:0]  mi_q   [8:11];

  // Pipe never holds off the sender.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= NumStages; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[1] <= start_i & ~busy_o;
      for (int i = 2; i <= NumStages; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q[1]  <= req_type_i;
    echo_q[1] <= '{year: year_in_i, month: month_in_i, day: day_in_i,
                   hour: hour_in_i, minute: minute_in_i, second: second_in_i};
    for (int i = 2; i <= NumStages - 1; i++) begin
      req_q[i]  <= req_q[i-1];
      echo_q[i] <= echo_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: year quotients by 100 / 400, time-of-day seconds, month offset
  // ---------------------------------------------------------------------------
  logic [11:0] s1_ym1;
  logic [24:0] s1_p_nq;
  logic [22:0] s1_p_n400;
  logic [24:0] s1_p_yq;
  logic [22:0] s1_p_y4q;

  logic [5:0]  s1_nq100_q;
  logic [3:0]  s1_n400_q;
  logic [5:0]  s1_yq100_q;
  logic [3:0]  s1_y4q100_q;
  logic [16:0] s1_hms_q;
  logic [8:0]  s1_cum_q;
  logic        s1_mgt2_q;
  logic [31:0] s1_unix_q;

  assign s1_ym1    = year_in_i - 12'd1;
  assign s1_p_nq   = 25'(s1_ym1) * 25'(Rcp100);
  assign s1_p_n400 = 23'(s1_ym1[11:2]) * 23'(Rcp100);
  assign s1_p_yq   = 25'(year_in_i) * 25'(Rcp100);
  assign s1_p_y4q  = 23'(year_in_i[11:2]) * 23'(Rcp100);

  always_ff @(posedge clk_i) begin
    s1_nq100_q  <= 6'(s1_p_nq >> Sh100);
    s1_n400_q   <= 4'(s1_p_n400 >> Sh100);
    s1_yq100_q  <= 6'(s1_p_yq >> Sh100);
    s1_y4q100_q <= 4'(s1_p_y4q >> Sh100);
    s1_hms_q    <= 17'(hour_in_i) * 17'd3600 + 17'(minute_in_i) * 17'd60
                   + 17'(second_in_i);
    s1_cum_q    <= days_before_mon(month_in_i);
    s1_mgt2_q   <= (month_in_i > 4'd2);
    s1_unix_q   <= unix_in_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: day count since epoch
  // ---------------------------------------------------------------------------
  logic [11:0] s2_y;
  logic [11:0] s2_ym1;
  logic        s2_leap;
  logic [31:0] s2_leaps;
  logic [31:0] s2_days_y;

  logic [31:0] s2_days_q;
  logic [16:0] s2_hms_q;
  logic [31:0] s2_unix_q;

  assign s2_y   = echo_q[1].year;
  assign s2_ym1 = s2_y - 12'd1;
  // Divisible by 4, and either not by 100 or by 400.
  assign s2_leap = (s2_y[1:0] == 2'd0) &&
                   ((s2_y != 12'(s1_yq100_q) * 12'd100) ||
                    (s2_y[11:2] == 10'(s1_y4q100_q) * 10'd100));
  assign s2_leaps  = 32'(s2_ym1[11:2]) - 32'(s1_nq100_q) + 32'(s1_n400_q);
  assign s2_days_y = (s2_y > EpochYear) ?
                     32'd365 * 32'(s2_y - EpochYear) + s2_leaps - LeapsTo1969 : '0;

  always_ff @(posedge clk_i) begin
    s2_days_q <= s2_days_y + 32'(s1_cum_q) + 32'(s1_mgt2_q & s2_leap)
                 + 32'(echo_q[1].day) - 32'd1;
    s2_hms_q  <= s1_hms_q;
    s2_unix_q <= s1_unix_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: Unix seconds (computed, or passed through); delay taps follow
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_q[2]) begin
      u_q[3] <= s2_unix_q;
    end else begin
      u_q[3] <= s2_days_q * 32'd86400 + 32'(s2_hms_q);
    end
    for (int i = 4; i <= 11; i++) begin
      u_q[i] <= u_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: whole days = u / 86400 = (u >> 7) / 675
  // ---------------------------------------------------------------------------
  logic [50:0] s4_p;
  logic [15:0] s4_dq_q;

  assign s4_p = 51'(u_q[3][31:7]) * 51'(Rcp675);

  always_ff @(posedge clk_i) begin
    s4_dq_q <= 16'(s4_p >> Sh675);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: seconds of day, weekday quotient, 400-year era
  // ---------------------------------------------------------------------------
  logic [16:0] s5_t;
  logic [19:0] s5_z;
  logic [34:0] s5_p7;
  logic [40:0] s5_pera;

  logic [16:0] s5_sod_q;
  logic [16:0] s5_t_q;
  logic [12:0] s5_tq7_q;
  logic [19:0] s5_z_q;

  assign s5_t    = 17'(s4_dq_q) + 17'd4;
  assign s5_z    = 20'(s4_dq_q) + EpochShift;
  assign s5_p7   = 35'(s5_t) * 35'(Rcp7);
  assign s5_pera = 41'(s5_z) * 41'(Rcp146097);

  always_ff @(posedge clk_i) begin
    s5_sod_q <= 17'(u_q[4] - 32'(s4_dq_q) * 32'd86400);
    s5_t_q   <= s5_t;
    s5_tq7_q <= 13'(s5_p7 >> Sh7);
    s5_z_q   <= s5_z;
    era_q[5] <= 3'(s5_pera >> Sh146097);
    for (int i = 6; i <= 11; i++) begin
      era_q[i] <= era_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: weekday, day of era, hour
  // ---------------------------------------------------------------------------
  logic [34:0] s6_phr;
  logic [16:0] s6_sod_q;

  assign s6_phr = 35'(s5_sod_q) * 35'(Rcp3600);

  always_ff @(posedge clk_i) begin
    wd_q[6]  <= 3'(s5_t_q - 17'(s5_tq7_q) * 17'd7);
    doe_q[6] <= 18'(s5_z_q - 20'(era_q[5]) * 20'd146097);
    hr_q[6]  <= 5'(s6_phr >> Sh3600);
    s6_sod_q <= s5_sod_q;
    for (int i = 7; i <= 11; i++) begin
      wd_q[i] <= wd_q[i-1];
      hr_q[i] <= hr_q[i-1];
    end
    for (int i = 7; i <= 9; i++) begin
      doe_q[i] <= doe_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: seconds within hour, leap-cycle corrections for year of era
  // ---------------------------------------------------------------------------
  logic [36:0] s7_p1460;
  logic [6:0]  s7_d1460_q;
  logic [2:0]  s7_d36524_q;
  logic        s7_d146096_q;

  assign s7_p1460 = 37'(doe_q[6]) * 37'(Rcp1460);

  always_ff @(posedge clk_i) begin
    rem_q[7]     <= 12'(s6_sod_q - 17'(hr_q[6]) * 17'd3600);
    s7_d1460_q   <= 7'(s7_p1460 >> Sh1460);
    s7_d36524_q  <= 3'(doe_q[6] >= 18'd36524) + 3'(doe_q[6] >= 18'd73048)
                    + 3'(doe_q[6] >= 18'd109572) + 3'(doe_q[6] >= 18'd146096);
    s7_d146096_q <= (doe_q[6] >= 18'd146096);
  end

  // ---------------------------------------------------------------------------
  // Stage 8: year-of-era numerator, minute
  // ---------------------------------------------------------------------------
  logic [24:0] s8_pmi;
  logic [17:0] s8_yn_q;

  assign s8_pmi = 25'(rem_q[7]) * 25'(Rcp60);

  always_ff @(posedge clk_i) begin
    s8_yn_q <= doe_q[7] - 18'(s7_d1460_q) + 18'(s7_d36524_q) - 18'(s7_d146096_q);
    mi_q[8] <= 6'(s8_pmi >> Sh60);
    rem_q[8] <= rem_q[7];
    for (int i = 9; i <= 11; i++) begin
      mi_q[i] <= mi_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: year of era, second
  // ---------------------------------------------------------------------------
  logic [36:0] s9_pyoe;
  logic [8:0]  s9_yoe_q;
  logic [5:0]  s9_sec_q;

  assign s9_pyoe = 37'(s8_yn_q) * 37'(Rcp365);

  always_ff @(posedge clk_i) begin
    s9_yoe_q <= 9'(s9_pyoe >> Sh365);
    s9_sec_q <= 6'(rem_q[8] - 12'(mi_q[8]) * 12'd60);
  end

  // ---------------------------------------------------------------------------
  // Stage 10: day of the March-based year
  // ---------------------------------------------------------------------------
  logic [1:0]  s10_yc100;
  logic [8:0]  s10_doy_q;
  logic [8:0]  s10_yoe_q;
  logic [5:0]  s10_sec_q;

  assign s10_yc100 = 2'(s9_yoe_q >= 9'd100) + 2'(s9_yoe_q >= 9'd200)
                     + 2'(s9_yoe_q >= 9'd300);

  always_ff @(posedge clk_i) begin
    s10_doy_q <= 9'(doe_q[9] - (18'(s9_yoe_q) * 18'd365 + 18'(s9_yoe_q[8:2])
                                - 18'(s10_yc100)));
    s10_yoe_q <= s9_yoe_q;
    s10_sec_q <= s9_sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 11: month index counted from March
  // ---------------------------------------------------------------------------
  logic [10:0] s11_v;
  logic [22:0] s11_pmp;
  logic [3:0]  s11_mp_q;
  logic [8:0]  s11_doy_q;
  logic [8:0]  s11_yoe_q;
  logic [5:0]  s11_sec_q;

  assign s11_v   = 11'(s10_doy_q) * 11'd5 + 11'd2;
  assign s11_pmp = 23'(s11_v) * 23'(Rcp153);

  always_ff @(posedge clk_i) begin
    s11_mp_q  <= 4'(s11_pmp >> Sh153);
    s11_doy_q <= s10_doy_q;
    s11_yoe_q <= s10_yoe_q;
    s11_sec_q <= s10_sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 12: civil date, mode select, output registers
  // ---------------------------------------------------------------------------
  logic [3:0]  s12_mon;
  logic [4:0]  s12_day;
  logic [11:0] s12_year;

  logic [31:0] out_unix_q;
  logic [11:0] out_year_q;
  logic [3:0]  out_mon_q;
  logic [4:0]  out_day_q;
  logic [4:0]  out_hr_q;
  logic [5:0]  out_mi_q;
  logic [5:0]  out_sec_q;
  logic [2:0]  out_wd_q;

  assign s12_mon  = (s11_mp_q < 4'd10) ? s11_mp_q + 4'd3 : s11_mp_q - 4'd9;
  assign s12_day  = 5'(s11_doy_q - days_before_mar(s11_mp_q) + 9'd1);
  // January and February belong to the next civil year.
  assign s12_year = 12'(s11_yoe_q) + 12'(era_q[11]) * 12'd400
                    + 12'(s12_mon <= 4'd2);

  always_ff @(posedge clk_i) begin
    out_unix_q <= u_q[11];
    out_wd_q   <= wd_q[11];
    if (req_q[11]) begin
      out_year_q <= s12_year;
      out_mon_q  <= s12_mon;
      out_day_q  <= s12_day;
      out_hr_q   <= hr_q[11];
      out_mi_q   <= mi_q[11];
      out_sec_q  <= s11_sec_q;
    end else begin
      out_year_q <= echo_q[11].year;
      out_mon_q  <= echo_q[11].month;
      out_day_q  <= echo_q[11].day;
      out_hr_q   <= echo_q[11].hour;
      out_mi_q   <= echo_q[11].minute;
      out_sec_q  <= echo_q[11].second;
    end
  end

  assign done_o       = vld_q[NumStages];
  assign unix_out_o   = out_unix_q;
  assign year_out_o   = out_year_q;
  assign month_out_o  = out_mon_q;
  assign day_out_o    = out_day_q;
  assign hour_out_o   = out_hr_q;
  assign minute_out_o = out_mi_q;
  assign second_out_o = out_sec_q;
  assign weekday_o    = out_wd_q;

endmodule

// File: verif/tb_unix_time_calendar_converter_top.sv
// Self-checking testbench for unix_time_calendar_converter_top.
// Depends on utcc_pkg (NumStages) and the converter RTL; needs no other file.
`timescale 1ns / 100ps

module tb_unix_time_calendar_converter_top;
  import utcc_pkg::*;

  // Request type codes on req_type_i.
  localparam logic CalToUnix = 1'b0;
  localparam logic UnixToCal = 1'b1;

  localparam int unsigned RandItems  = 880;
  localparam int unsigned CycleLimit = 100000;

  // Days before month m in a common year; months 13 and 14 count 31 days each.
  localparam logic [31:0] DaysBeforeMonth [16] = '{
    32'd0,   32'd0,   32'd31,  32'd59,  32'd90,  32'd120, 32'd151, 32'd181,
    32'd212, 32'd243, 32'd273, 32'd304, 32'd334, 32'd365, 32'd396, 32'd427
  };

  // One conversion request, field by field as on the input ports.
  typedef struct packed {
    logic        req;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] unix;
  } conv_req_t;

  // One conversion result, as on the output ports.
  typedef struct packed {
    logic [31:0] unix;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } conv_res_t;

  // Directed row: the result is typed in only where has_exp is set.
  typedef struct {
    bit        has_exp;
    conv_req_t stim;
    conv_res_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [11:0] year_in_i;
  logic [3:0]  month_in_i;
  logic [4:0]  day_in_i;
  logic [4:0]  hour_in_i;
  logic [5:0]  minute_in_i;
  logic [5:0]  second_in_i;
  logic [31:0] unix_in_i;
  logic        done_o;
  logic [31:0] unix_out_o;
  logic [11:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;
  logic [2:0]  weekday_o;

  // Results still owed by the converter, oldest first.
  conv_res_t   pending_results[$];
  dir_row_t    dir_rows[$];

  int unsigned err_cnt     = 0;
  int unsigned checked_cnt = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned cal_cnt     = 0;
  int unsigned unix_cnt    = 0;
  int unsigned drain_cnt   = 0;

  unix_time_calendar_converter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .year_in_i    (year_in_i),
    .month_in_i   (month_in_i),
    .day_in_i     (day_in_i),
    .hour_in_i    (hour_in_i),
    .minute_in_i  (minute_in_i),
    .second_in_i  (second_in_i),
    .unix_in_i    (unix_in_i),
    .done_o       (done_o),
    .unix_out_o   (unix_out_o),
    .year_out_o   (year_out_o),
    .month_out_o  (month_out_o),
    .day_out_o    (day_out_o),
    .hour_out_o   (hour_out_o),
    .minute_out_o (minute_out_o),
    .second_out_o (second_out_o),
    .weekday_o    (weekday_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, all in 32-bit unsigned so sums wrap as the block does.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] is_leap(input logic [31:0] y);
    return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 32'd1 : 32'd0;
  endfunction

  // Leap years in 1..n.
  function automatic logic [31:0] leaps_upto(input logic [31:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Expected result of one request.
  function automatic conv_res_t calc_expected(input conv_req_t r);
    conv_res_t   res;
    logic [31:0] y, m, d, h, mi, s, u;
    logic [31:0] days, z, era, doe, yoe, doy, mp;
    y  = 32'(r.year);
    m  = 32'(r.month);
    d  = 32'(r.day);
    h  = 32'(r.hour);
    mi = 32'(r.minute);
    s  = 32'(r.second);
    u  = r.unix;
    if (r.req == CalToUnix) begin
      // Whole years only from 1971 on; earlier years add nothing.
      days = 32'd0;
      if (y > 32'd1970)
        days = 32'd365 * (y - 32'd1970) + leaps_upto(y - 32'd1) - leaps_upto(32'd1969);
      days = days + DaysBeforeMonth[r.month];
      if (m > 32'd2)
        days = days + is_leap(y);
      // Day zero wraps to minus one day.
      days = days + d - 32'd1;
      u = days * 32'd86400 + h * 32'd3600 + mi * 32'd60 + s;
    end else begin
      s    = u % 60;
      mi   = (u / 60) % 60;
      h    = (u / 3600) % 24;
      days = u / 86400;
      // Count from 1 March of year 0 so the leap day ends each year.
      z    = days + 32'd719468;
      era  = z / 146097;
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (32'd365 * yoe + yoe / 4 - yoe / 100);
      mp   = (32'd5 * doy + 32'd2) / 153;
      d    = doy - (32'd153 * mp + 32'd2) / 5 + 32'd1;
      m    = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
      y    = yoe + era * 400 + ((m <= 32'd2) ? 32'd1 : 32'd0);
    end
    res.unix    = u;
    res.year    = 12'(y);
    res.month   = 4'(m);
    res.day     = 5'(d);
    res.hour    = 5'(h);
    res.minute  = 6'(mi);
    res.second  = 6'(s);
    res.weekday = 3'(((u / 86400) + 32'd4) % 7);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // A well-formed calendar request between 1970 and 2106.
  function automatic conv_req_t rand_calendar();
    conv_req_t   r;
    logic [31:0] dim;
    r        = '0;
    r.req    = CalToUnix;
    r.year   = 12'($urandom_range(1970, 2106));
    r.month  = 4'($urandom_range(1, 12));
    if (r.month == 4'd2)
      dim = 32'd28 + is_leap(32'(r.year));
    else
      dim = DaysBeforeMonth[r.month + 4'd1] - DaysBeforeMonth[r.month];
    r.day    = 5'($urandom_range(1, dim));
    r.hour   = 5'($urandom_range(0, 23));
    r.minute = 6'($urandom_range(0, 59));
    r.second = 6'($urandom_range(0, 59));
    r.unix   = $urandom;
    return r;
  endfunction

  function automatic conv_req_t random_req();
    conv_req_t   r;
    conv_req_t   cal;
    conv_res_t   bnd;
    int unsigned pick;
    // Start from full-width noise on every field; unused fields stay noisy.
    r.req    = 1'($urandom_range(0, 1));
    r.year   = 12'($urandom);
    r.month  = 4'($urandom);
    r.day    = 5'($urandom);
    r.hour   = 5'($urandom);
    r.minute = 6'($urandom);
    r.second = 6'($urandom);
    r.unix   = $urandom;
    pick     = $urandom_range(0, 99);
    if (r.req == CalToUnix) begin
      if (pick < 80) begin
        cal      = rand_calendar();
        cal.unix = r.unix;
        r        = cal;
      end
    end else if (pick >= 40 && pick < 75) begin
      // Land right on a day, month or year boundary, one second either side.
      cal = rand_calendar();
      if ($urandom_range(0, 1) == 0) cal.day = 5'd1;
      cal.hour   = 5'd0;
      cal.minute = 6'd0;
      cal.second = 6'd0;
      bnd    = calc_expected(cal);
      r.unix = bnd.unix + 32'($urandom_range(0, 2)) - 32'd1;
    end else if (pick >= 75) begin
      // Close to either end of the 32-bit range.
      if ($urandom_range(0, 1) == 0)
        r.unix = 32'($urandom_range(0, 200000));
      else
        r.unix = 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side. Ports change with nonblocking assignments at the rising edge;
  // the transfer is seen on the next edge with start_i high and busy_o low.
  // ---------------------------------------------------------------------------
  task automatic drive_req(input conv_req_t r, input conv_res_t exp);
    start_i     <= 1'b1;
    req_type_i  <= r.req;
    year_in_i   <= r.year;
    month_in_i  <= r.month;
    day_in_i    <= r.day;
    hour_in_i   <= r.hour;
    minute_in_i <= r.minute;
    second_in_i <= r.second;
    unix_in_i   <= r.unix;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(exp);
    if (r.req == CalToUnix) cal_cnt++;
    else unix_cnt++;
  endtask

  task automatic idle(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: done_o marks a one-cycle result that must be taken as shown.
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [31:0] exp,
                           input logic [31:0] act);
    if (exp !== act) begin
      err_cnt++;
      $error("%s: expected %0d, actual %0d", name, exp, act);
    end
  endtask

  always @(posedge clk_i) begin
    conv_res_t exp;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $error("result strobe with no request outstanding");
      end else begin
        exp = pending_results.pop_front();
        cmp_field("unix_out", exp.unix, unix_out_o);
        cmp_field("year_out", 32'(exp.year), 32'(year_out_o));
        cmp_field("month_out", 32'(exp.month), 32'(month_out_o));
        cmp_field("day_out", 32'(exp.day), 32'(day_out_o));
        cmp_field("hour_out", 32'(exp.hour), 32'(hour_out_o));
        cmp_field("minute_out", 32'(exp.minute), 32'(minute_out_o));
        cmp_field("second_out", 32'(exp.second), 32'(second_out_o));
        cmp_field("weekday", 32'(exp.weekday), 32'(weekday_o));
        checked_cnt++;
      end
    end
  end

  // Watchdog: a hung pipe or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_unix_time_calendar_converter_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    conv_req_t   r;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_type_i  <= CalToUnix;
    year_in_i   <= '0;
    month_in_i  <= '0;
    day_in_i    <= '0;
    hour_in_i   <= '0;
    minute_in_i <= '0;
    second_in_i <= '0;
    unix_in_i   <= '0;

    // Directed rows: epoch, both ends of the range, 2038 rollover, day zero,
    // leap and century rules, years before the epoch, months 0 and 13..15,
    // out-of-range time fields and the all-ones overflow case.
    dir_rows.push_back('{1'b1,
      '{UnixToCal, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'd0},
      '{32'd0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4}});
    dir_rows.push_back('{1'b1,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd0}});
    dir_rows.push_back('{1'b1,
      '{CalToUnix, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFF},
      '{32'd0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4}});
    dir_rows.push_back('{1'b1,
      '{CalToUnix, 12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 32'd0},
      '{32'h7FFF_FFFF, 12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 3'd2}});
    dir_rows.push_back('{1'b1,
      '{CalToUnix, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 32'd0},
      '{32'hFFFF_FFFF, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd0}});
    dir_rows.push_back('{1'b1,
      '{CalToUnix, 12'd1970, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0},
      '{32'd4294880896, 12'd1970, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 3'd6}});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd1969, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2024, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2024, 4'd13, 5'd5, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2023, 4'd14, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2023, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd2024, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{CalToUnix, 12'd1972, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd951782400}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd951868800}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd4107542400}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd86399}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd86400}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'h8000_0000}, '0});
    dir_rows.push_back('{1'b0,
      '{UnixToCal, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd1234567890}, '0});

    // Single reset at the start of the run.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, back to back with one short gap halfway through.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp)
        drive_req(dir_rows[i].stim, dir_rows[i].res);
      else
        drive_req(dir_rows[i].stim, calc_expected(dir_rows[i].stim));
      if (i == 12) idle(3);
    end

    // Let the pipe empty out completely before the random part.
    wait_drained();

    // Random part: bursts of random length, random gaps (sometimes none),
    // and now and then a full drain of the pipe.
    burst_left = $urandom_range(1, 40);
    for (int unsigned n = 0; n < RandItems; n++) begin
      r = random_req();
      drive_req(r, calc_expected(r));
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 29) == 0)
          wait_drained();
        else if (gap != 0)
          idle(gap);
        burst_left = $urandom_range(1, 40);
      end
    end
    start_i <= 1'b0;

    // Wait for the last results, then keep watching for stray strobes.
    while (pending_results.size() != 0) @(posedge clk_i);
    while (drain_cnt < 2 * NumStages + 4) begin
      @(posedge clk_i);
      drain_cnt++;
    end

    $display("Checked %0d results: %0d calendar-to-unix, %0d unix-to-calendar requests",
             checked_cnt, cal_cnt, unix_cnt);
    $display("Directed edge cases plus random bursts with gaps and full drains");
    if (err_cnt == 0) begin
      $display("tb_unix_time_calendar_converter_top OK");
    end else begin
      $display("tb_unix_time_calendar_converter_top NOT OK");
    end
    $finish;
  end

endmodule
